FILE: hw/rtl/rmd_pkg.sv
// Package for the RIPEMD-160 engine: step tables, constants and functions.
package rmd_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned StepCount = 80;

  localparam logic [4:0][31:0] InitChain = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  typedef logic [31:0] word_t;

  function automatic logic [3:0] sel_left(input logic [6:0] j);
    logic [3:0] r;
    logic [0:79][3:0] t;
    t = {4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
         4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
         4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
         4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2,
         4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,4'd13};
    r = (j < 7'd80) ? t[j] : 4'd0;
    return r;
  endfunction

  function automatic logic [3:0] sel_right(input logic [6:0] j);
    logic [3:0] r;
    logic [0:79][3:0] t;
    t = {4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12,
         4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
         4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
         4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14,
         4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,4'd11};
    r = (j < 7'd80) ? t[j] : 4'd0;
    return r;
  endfunction

  function automatic logic [3:0] rot_left(input logic [6:0] j);
    logic [3:0] r;
    logic [0:79][3:0] t;
    t = {4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,4'd7,4'd9,4'd8,
         4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,4'd13,4'd12,
         4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,4'd7,4'd5,
         4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,4'd5,4'd12,
         4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,4'd5,4'd6};
    r = (j < 7'd80) ? t[j] : 4'd0;
    return r;
  endfunction

  function automatic logic [3:0] rot_right(input logic [6:0] j);
    logic [3:0] r;
    logic [0:79][3:0] t;
    t = {4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,4'd12,4'd6,
         4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,4'd13,4'd11,
         4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,4'd7,4'd5,
         4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,4'd15,4'd8,
         4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,4'd11,4'd11};
    r = (j < 7'd80) ? t[j] : 4'd0;
    return r;
  endfunction

  function automatic word_t add_left(input logic [2:0] rnd);
    word_t r;
    case (rnd)
      3'd0: r = 32'h00000000;
      3'd1: r = 32'h5A827999;
      3'd2: r = 32'h6ED9EBA1;
      3'd3: r = 32'h8F1BBCDC;
      default: r = 32'hA953FD4E;
    endcase
    return r;
  endfunction

  function automatic word_t add_right(input logic [2:0] rnd);
    word_t r;
    case (rnd)
      3'd0: r = 32'h50A28BE6;
      3'd1: r = 32'h5C4DD124;
      3'd2: r = 32'h6D703EF3;
      3'd3: r = 32'h7A6D76E9;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic word_t bool_fn(input logic [2:0] sel, input word_t x, input word_t y,
                                    input word_t z);
    word_t r;
    case (sel)
      3'd0: r = x ^ y ^ z;
      3'd1: r = (x & y) | (~x & z);
      3'd2: r = (x | ~y) ^ z;
      3'd3: r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

  function automatic word_t rotl(input word_t v, input logic [4:0] n);
    logic [63:0] d;
    d = {v, v} << n;
    return d[63:32];
  endfunction

  // One step of a line: {a,b,c,d,e} in index order 0..4.
  function automatic logic [4:0][31:0] line_step(input logic [4:0][31:0] ln, input word_t f,
                                                 input word_t w, input word_t k,
                                                 input logic [3:0] s);
    logic [4:0][31:0] o;
    word_t t;
    t = rotl(ln[0] + f + w + k, {1'b0, s}) + ln[4];
    o[0] = ln[4];
    o[4] = ln[3];
    o[3] = rotl(ln[2], 5'd10);
    o[2] = ln[1];
    o[1] = t;
    return o;
  endfunction

endpackage

FILE: hw/rtl/rmd_block_ram.sv
// Sixteen-word message block memory, one write and two registered reads.
module rmd_block_ram (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [3:0]  raddr_a,
  input  logic [3:0]  raddr_b,
  output logic [31:0] rdata_a,
  output logic [31:0] rdata_b
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hw/rtl/ripemd160_hash_engine.sv
// RIPEMD-160 engine top level: byte packing, padding, compression and digest output.
//
// Input channel s_axis: one message byte per item in tdata, tuser = byte_present,
// tlast = message_end. A tlast item with tuser low ends the message with no byte.
// Output channel m_axis: five items per message, tdata = digest word, tuser holds
// word_number, tlast marks the fifth word.
// A data byte reads the partial block word, then writes it back.
// Every 64th byte starts a compression: a read state, one block memory read per
// step with both lines advancing in the same cycle, then a fold of the chain.
// Message end appends padding at one word per cycle and runs one or two more
// compressions, then presents the five words from the chain register.
// The input is held off while compressing, padding or while digest words wait;
// a stalled receiver just freezes the output word in place.
// Reset (rst, synchronous) returns the chain to the IV and the byte count to zero;
// block memory contents are left as they are.
module ripemd160_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_number
  output logic        m_axis_tlast    // final_word
);

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE_WR, S_STEP_RD, S_STEP, S_FOLD, S_PAD, S_OUT
  } state_t;

  state_t      state;
  logic [4:0][31:0] chain, left_ln, right_ln;
  logic [63:0] byte_total;
  logic [6:0]  step;
  logic [7:0]  data_byte;
  logic        pad_mode, pad_last, do_final;
  logic [3:0]  pad_idx;
  logic [2:0]  out_idx;

  logic        we;
  logic [3:0]  waddr, raddr_a, raddr_b;
  logic [31:0] wdata, rd_a, rd_b;
  logic [63:0] bits;
  logic [1:0]  bpos;
  logic [3:0]  widx;
  logic [2:0]  rnd;
  logic [6:0]  step_rd;

  assign bits  = byte_total << 3;
  assign bpos  = byte_total[1:0];
  assign widx  = byte_total[5:2];
  assign rnd   = step[6:4] > 3'd4 ? 3'd4 : step[6:4];
  assign step_rd = (state == S_STEP) ? step + 7'd1 : 7'd0;

  rmd_block_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rd_a), .rdata_b(rd_b)
  );

  // Reads: partial word during byte intake, step words during compression.
  always_comb begin
    raddr_a = widx;
    raddr_b = widx;
    if (state == S_STEP_RD || state == S_STEP) begin
      raddr_a = rmd_pkg::sel_left(step_rd);
      raddr_b = rmd_pkg::sel_right(step_rd);
    end
  end

  // Padding word for index pad_idx given bytes already placed in the current word.
  function automatic logic [31:0] pad_word(input logic [3:0] idx, input logic [31:0] old,
                                           input logic [3:0] cur, input logic [1:0] bp,
                                           input logic lenblk, input logic [63:0] b);
    logic [31:0] r;
    r = 32'd0;
    if (lenblk && idx == 4'd14) begin
      r = b[31:0];
    end else if (lenblk && idx == 4'd15) begin
      r = b[63:32];
    end else if (idx == cur) begin
      case (bp)
        2'd0: r = 32'h00000080;
        2'd1: r = {16'd0, 8'h80, old[7:0]};
        2'd2: r = {8'h80, old[15:0]};
        default: r = {8'h80, old[23:0]};
      endcase
    end
    return r;
  endfunction

  logic [31:0] cur_word;
  logic        pad_first;

  always_comb begin
    we = 1'b0;
    waddr = widx;
    wdata = 32'd0;
    case (bpos)
      2'd0: cur_word = {24'd0, data_byte};
      2'd1: cur_word = {16'd0, data_byte, rd_a[7:0]};
      2'd2: cur_word = {8'd0, data_byte, rd_a[15:0]};
      default: cur_word = {data_byte, rd_a[23:0]};
    endcase
    if (state == S_BYTE_WR) begin
      we = 1'b1;
      wdata = cur_word;
    end else if (state == S_PAD) begin
      // keep the message words ahead of the marker
      we = !(pad_first && (pad_idx < widx));
      waddr = pad_idx;
      wdata = pad_first ? pad_word(pad_idx, rd_a, widx, bpos, pad_last, bits)
                        : pad_word(pad_idx, rd_a, 4'd15, 2'd0, pad_last, bits);
    end
  end

  // pad_first: this pad block holds the 0x80 marker.
  logic [4:0][31:0] left_next, right_next;
  always_comb begin
    left_next = rmd_pkg::line_step(left_ln,
      rmd_pkg::bool_fn(rnd, left_ln[1], left_ln[2], left_ln[3]), rd_a,
      rmd_pkg::add_left(rnd), rmd_pkg::rot_left(step));
    right_next = rmd_pkg::line_step(right_ln,
      rmd_pkg::bool_fn(3'd4 - rnd, right_ln[1], right_ln[2], right_ln[3]), rd_b,
      rmd_pkg::add_right(rnd), rmd_pkg::rot_right(step));
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = chain[out_idx];
  assign m_axis_tuser  = out_idx;
  assign m_axis_tlast  = (out_idx == 3'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chain <= rmd_pkg::InitChain;
      byte_total <= 64'd0;
      step <= 7'd0;
      pad_mode <= 1'b0;
      pad_last <= 1'b0;
      pad_first <= 1'b0;
      do_final <= 1'b0;
      pad_idx <= 4'd0;
      out_idx <= 3'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            data_byte <= s_axis_tdata;
            do_final <= s_axis_tlast;
            if (s_axis_tuser) begin
              state <= S_BYTE_WR;
            end else if (s_axis_tlast) begin
              state <= S_STEP_RD;   // through the read state to padding
              pad_mode <= 1'b1;
              pad_first <= 1'b1;
              pad_last <= (byte_total[5:0] < 6'd56);
              pad_idx <= 4'd0;
              step <= 7'd127;
            end
          end
        end
        S_BYTE_WR: begin
          byte_total <= byte_total + 64'd1;
          if (byte_total[5:0] == 6'd63) begin
            state <= S_STEP_RD;
            pad_mode <= 1'b0;
            step <= 7'd0;
          end else if (do_final) begin
            state <= S_STEP_RD;
            pad_mode <= 1'b1;
            pad_first <= 1'b1;
            pad_last <= (byte_total[5:0] < 6'd55);
            pad_idx <= 4'd0;
            step <= 7'd127;
          end else begin
            state <= S_IDLE;
          end
        end
        S_STEP_RD: begin
          left_ln <= chain;
          right_ln <= chain;
          if (pad_mode && step == 7'd127) begin
            state <= S_PAD;
          end else begin
            step <= 7'd0;
            state <= S_STEP;
          end
        end
        S_PAD: begin
          pad_idx <= pad_idx + 4'd1;
          if (pad_idx == 4'd15) begin
            state <= S_STEP_RD;
            step <= 7'd0;
          end
        end
        S_STEP: begin
          left_ln <= left_next;
          right_ln <= right_next;
          step <= step + 7'd1;
          if (step == 7'd79) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[1] + left_ln[2] + right_ln[3];
          chain[1] <= chain[2] + left_ln[3] + right_ln[4];
          chain[2] <= chain[3] + left_ln[4] + right_ln[0];
          chain[3] <= chain[4] + left_ln[0] + right_ln[1];
          chain[4] <= chain[0] + left_ln[1] + right_ln[2];
          if (!pad_mode && !do_final) begin
            state <= S_IDLE;
          end else if (!pad_mode) begin
            pad_mode <= 1'b1;
            pad_first <= 1'b1;
            pad_last <= 1'b1;
            pad_idx <= 4'd0;
            step <= 7'd127;
            state <= S_STEP_RD;
          end else if (!pad_last) begin
            pad_first <= 1'b0;
            pad_last <= 1'b1;
            pad_idx <= 4'd0;
            step <= 7'd127;
            state <= S_STEP_RD;
          end else begin
            out_idx <= 3'd0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd4) begin
              chain <= rmd_pkg::InitChain;
              byte_total <= 64'd0;
              pad_mode <= 1'b0;
              do_final <= 1'b0;
              out_idx <= 3'd0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_idx <= 3'd4) else $error("word index out of range");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open while emitting");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_idx))
    else $error("digest word dropped under stall");
`endif

endmodule
